// ===== hdl/tw_pkg.sv =====
// ----------------------------------------------------------------------------
// tw_pkg
// shared types and constants of the timer wheel multiplexer
// ----------------------------------------------------------------------------
`default_nettype none

package tw_pkg;

  localparam int MaxTimers   = 16;
  localparam int IdxW        = $clog2(MaxTimers);
  localparam int WheelSpanMs = 1000;
  localparam int LowPrecDiv  = 4;
  localparam int ResMin      = 5;
  localparam int ResMax      = WheelSpanMs / LowPrecDiv;
  localparam int ResReset    = 20;
  localparam int NSlotsReset = WheelSpanMs / ResReset;

  localparam int TagW  = 16;
  localparam int PerW  = 16;
  localparam int TimeW = 32;
  localparam int ResW  = 8;
  localparam int SlotW = 8;
  localparam int FracW = 24;
  localparam int LostW = 16;
  localparam int FracSumW = FracW + 1;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_TICK   = 2'd2
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_NDIV,
    S_RB_RD,
    S_RB_EV,
    S_CALC1,
    S_CALC2,
    S_WR,
    S_RM_RD,
    S_RM_EV,
    S_RM_END,
    S_TW_RD,
    S_TW_EV,
    S_TL_RD,
    S_TL_EV,
    S_TL_DIV,
    S_TL_WR,
    S_TEND
  } state_e;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [PerW-1:0]  period;
    logic             lp;
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] stride;
    logic [FracW-1:0] frac;
    logic [LostW-1:0] lost;
    logic [TimeW-1:0] last_fired;
    logic [TimeW-1:0] next_due;
  } entry_t;

  localparam int EntW = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hdl/tw_ram.sv =====
// ----------------------------------------------------------------------------
// tw_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tw_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/timer_wheel_multiplexer.sv =====
// ----------------------------------------------------------------------------
// timer_wheel_multiplexer
// periodic timer table on a hashed timing wheel, driven by tick beats
// ----------------------------------------------------------------------------
// add: a low precision entry is written directly, a wheel entry goes through the
// serial divider; remove: a sweep over all 16 entries; tick: a wheel pass over
// every entry, then on a quarter turn a low precision pass with a divide per due
// timer (32-step divider); one item at a time, busy high while the sequencer runs
// resolution write: slot count divide, then a rebuild sweep that re-places every
// wheel timer; results cannot be stalled by the receiver
// reset: table empty, resolution 20 ms, 50 slots, current slot 0
`default_nettype none

module timer_wheel_multiplexer (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                mode_i,
  input  wire logic [tw_pkg::TagW-1:0]   timer_tag_i,
  input  wire logic [tw_pkg::PerW-1:0]   period_ms_i,
  input  wire logic [tw_pkg::TimeW-1:0]  now_ms_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [tw_pkg::ResW-1:0]   cfg_wdata_i,
  output logic                           result_strobe_o,
  output logic      [tw_pkg::TagW-1:0]   fired_tag_o,
  output logic      [tw_pkg::TimeW-1:0]  skipped_o,
  output logic      [tw_pkg::TimeW-1:0]  last_delay_o,
  output logic                           last_o
);

  // sequencer and table control
  tw_pkg::state_e                   state_q, state_d;
  logic [tw_pkg::IdxW-1:0]          idx_q, idx_d;
  logic [tw_pkg::MaxTimers-1:0]     valid_q, valid_d;
  logic [tw_pkg::ResW-1:0]          res_q, res_d;
  logic [tw_pkg::SlotW-1:0]         nsl_q, nsl_d;
  logic [tw_pkg::SlotW-1:0]         cur_q, cur_d;
  logic [tw_pkg::SlotW-1:0]         qc_q, qc_d;
  logic                             rb_q, rb_d;
  logic                             fw_q, fw_d, fl_q, fl_d;
  logic [tw_pkg::IdxW-1:0]          wi_q, wi_d, li_q, li_d;

  // working registers
  tw_pkg::entry_t                   ent_q, ent_d;
  logic [tw_pkg::TagW-1:0]          tag_q, tag_d;
  logic [tw_pkg::TimeW-1:0]         now_q, now_d;
  logic [tw_pkg::TimeW-1:0]         prod_q, prod_d;

  // serial divider, one quotient bit per cycle
  logic                             div_start;
  logic [tw_pkg::TimeW-1:0]         div_num;
  logic [tw_pkg::PerW-1:0]          div_den;
  logic                             div_busy_q;
  logic [4:0]                       div_cnt_q;
  logic [tw_pkg::PerW:0]            div_rem_q;
  logic [tw_pkg::TimeW-1:0]         div_quo_q;
  logic [tw_pkg::PerW-1:0]          div_den_q;
  logic [tw_pkg::PerW:0]            div_trial;

  // entry memory
  logic                             ram_we;
  tw_pkg::entry_t                   ram_wdata;
  logic [tw_pkg::EntW-1:0]          ram_rdata;
  tw_pkg::entry_t                   rd_ent;

  // result staging: one beat held back so the final one can carry last
  logic                             push, flush;
  logic [tw_pkg::TagW-1:0]          push_tag;
  logic [tw_pkg::TimeW-1:0]         push_skip, push_dly;
  logic                             pend_v_q;
  logic [tw_pkg::TagW-1:0]          pend_tag_q;
  logic [tw_pkg::TimeW-1:0]         pend_skip_q, pend_dly_q;
  logic                             strobe_q, olast_q;
  logic [tw_pkg::TagW-1:0]          otag_q;
  logic [tw_pkg::TimeW-1:0]         oskip_q, odly_q;

  // helpers
  logic [tw_pkg::ResW-1:0]          res_clamp;
  logic                             free_found;
  logic [tw_pkg::IdxW-1:0]          free_idx;
  logic [tw_pkg::PerW-1:0]          per_eff;
  logic                             idx_last;

  tw_ram #(
    .Width (tw_pkg::EntW),
    .Depth (tw_pkg::MaxTimers)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign rd_ent   = tw_pkg::entry_t'(ram_rdata);
  assign busy     = (state_q != tw_pkg::S_IDLE);
  assign idx_last = (idx_q == tw_pkg::IdxW'(tw_pkg::MaxTimers - 1));
  assign per_eff  = (period_ms_i == '0) ? tw_pkg::PerW'(1) : period_ms_i;

  // register clamp to the legal resolution range
  always_comb begin
    if (cfg_wdata_i < tw_pkg::ResW'(tw_pkg::ResMin)) begin
      res_clamp = tw_pkg::ResW'(tw_pkg::ResMin);
    end else if (cfg_wdata_i > tw_pkg::ResW'(tw_pkg::ResMax)) begin
      res_clamp = tw_pkg::ResW'(tw_pkg::ResMax);
    end else begin
      res_clamp = cfg_wdata_i;
    end
  end

  // lowest free table entry
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = tw_pkg::MaxTimers - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = tw_pkg::IdxW'(i);
      end
    end
  end

  // divider datapath
  assign div_trial = {div_rem_q[tw_pkg::PerW-1:0], div_quo_q[tw_pkg::TimeW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + 5'd1;
      if (&div_cnt_q) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_rem_q <= '0;
      div_quo_q <= div_num;
      div_den_q <= div_den;
    end else if (div_busy_q) begin
      if (div_trial >= {1'b0, div_den_q}) begin
        div_rem_q <= div_trial - {1'b0, div_den_q};
        div_quo_q <= {div_quo_q[tw_pkg::TimeW-2:0], 1'b1};
      end else begin
        div_rem_q <= div_trial;
        div_quo_q <= {div_quo_q[tw_pkg::TimeW-2:0], 1'b0};
      end
    end
  end

  // control state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tw_pkg::S_IDLE;
      idx_q   <= '0;
      valid_q <= '0;
      res_q   <= tw_pkg::ResW'(tw_pkg::ResReset);
      nsl_q   <= tw_pkg::SlotW'(tw_pkg::NSlotsReset);
      cur_q   <= '0;
      qc_q    <= '0;
      rb_q    <= 1'b0;
      fw_q    <= 1'b0;
      fl_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      res_q   <= res_d;
      nsl_q   <= nsl_d;
      cur_q   <= cur_d;
      qc_q    <= qc_d;
      rb_q    <= rb_d;
      fw_q    <= fw_d;
      fl_q    <= fl_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    tag_q  <= tag_d;
    now_q  <= now_d;
    prod_q <= prod_d;
    wi_q   <= wi_d;
    li_q   <= li_d;
  end

  // sequencer
  always_comb begin
    logic [tw_pkg::SlotW:0]          s9;
    logic [tw_pkg::SlotW-1:0]        base;
    logic [tw_pkg::TimeW-1:0]        dly;
    logic [tw_pkg::TimeW-1:0]        diff;
    logic [tw_pkg::FracSumW-1:0]     lsum;
    tw_pkg::entry_t                  e_w;

    state_d   = state_q;
    idx_d     = idx_q;
    valid_d   = valid_q;
    res_d     = res_q;
    nsl_d     = nsl_q;
    cur_d     = cur_q;
    qc_d      = qc_q;
    rb_d      = rb_q;
    fw_d      = fw_q;
    fl_d      = fl_q;
    wi_d      = wi_q;
    li_d      = li_q;
    ent_d     = ent_q;
    tag_d     = tag_q;
    now_d     = now_q;
    prod_d    = prod_q;
    ram_we    = 1'b0;
    ram_wdata = ent_q;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    push      = 1'b0;
    push_tag  = '0;
    push_skip = '0;
    push_dly  = '0;
    flush     = 1'b0;
    s9        = '0;
    base      = '0;
    dly       = '0;
    diff      = '0;
    lsum      = '0;
    e_w       = rd_ent;

    unique case (state_q)
      tw_pkg::S_IDLE: begin
        if (cfg_we_i) begin
          if (res_clamp != res_q) begin
            // new resolution: slot count, then re-place every wheel timer
            res_d     = res_clamp;
            cur_d     = '0;
            qc_d      = '0;
            div_start = 1'b1;
            div_num   = tw_pkg::TimeW'(tw_pkg::WheelSpanMs);
            div_den   = tw_pkg::PerW'(res_clamp);
            state_d   = tw_pkg::S_NDIV;
          end
        end else if (start) begin
          case (mode_i)
            tw_pkg::MODE_ADD: begin
              if (free_found) begin
                idx_d            = free_idx;
                rb_d             = 1'b0;
                ent_d            = '0;
                ent_d.tag        = timer_tag_i;
                ent_d.period     = per_eff;
                ent_d.lp         = (per_eff >= tw_pkg::PerW'(tw_pkg::WheelSpanMs));
                if (ent_d.lp) begin
                  ent_d.next_due = now_ms_i + tw_pkg::TimeW'(per_eff);
                  state_d        = tw_pkg::S_WR;
                end else begin
                  div_start      = 1'b1;
                  div_num        = tw_pkg::TimeW'(per_eff);
                  div_den        = tw_pkg::PerW'(res_q);
                  state_d        = tw_pkg::S_CALC1;
                end
              end
            end
            tw_pkg::MODE_REMOVE: begin
              tag_d   = timer_tag_i;
              idx_d   = '0;
              fw_d    = 1'b0;
              fl_d    = 1'b0;
              state_d = tw_pkg::S_RM_RD;
            end
            tw_pkg::MODE_TICK: begin
              now_d   = now_ms_i;
              idx_d   = '0;
              state_d = tw_pkg::S_TW_RD;
            end
            default: begin
            end
          endcase
        end
      end

      tw_pkg::S_NDIV: begin
        if (!div_busy_q) begin
          nsl_d   = div_quo_q[tw_pkg::SlotW-1:0];
          idx_d   = '0;
          rb_d    = 1'b1;
          state_d = tw_pkg::S_RB_RD;
        end
      end

      tw_pkg::S_RB_RD: begin
        state_d = tw_pkg::S_RB_EV;
      end

      tw_pkg::S_RB_EV: begin
        ent_d = rd_ent;
        if (valid_q[idx_q] && !rd_ent.lp) begin
          div_start = 1'b1;
          div_num   = tw_pkg::TimeW'(rd_ent.period);
          div_den   = tw_pkg::PerW'(res_q);
          state_d   = tw_pkg::S_CALC1;
        end else if (idx_last) begin
          state_d = tw_pkg::S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = tw_pkg::S_RB_RD;
        end
      end

      // stride = period / res, slot = (base + stride) mod slots
      tw_pkg::S_CALC1: begin
        if (!div_busy_q) begin
          base         = rb_q ? '0 : cur_q;
          ent_d.stride = div_quo_q[tw_pkg::SlotW-1:0];
          s9           = {1'b0, base} + {1'b0, div_quo_q[tw_pkg::SlotW-1:0]};
          if (s9 >= {1'b0, nsl_q}) begin
            s9 = s9 - {1'b0, nsl_q};
          end
          ent_d.slot = s9[tw_pkg::SlotW-1:0];
          if (ent_q.period < tw_pkg::PerW'(res_q)) begin
            // per-tick fraction lost for periods below the resolution
            div_start = 1'b1;
            div_num   = {8'd0, res_q - ent_q.period[tw_pkg::ResW-1:0], 16'd0};
            div_den   = ent_q.period;
            state_d   = tw_pkg::S_CALC2;
          end else begin
            ent_d.frac = '0;
            state_d    = tw_pkg::S_WR;
          end
        end
      end

      tw_pkg::S_CALC2: begin
        if (!div_busy_q) begin
          ent_d.frac = div_quo_q[tw_pkg::FracW-1:0];
          state_d    = tw_pkg::S_WR;
        end
      end

      tw_pkg::S_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ent_q;
        if (rb_q) begin
          if (idx_last) begin
            state_d = tw_pkg::S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = tw_pkg::S_RB_RD;
          end
        end else begin
          valid_d[idx_q] = 1'b1;
          state_d        = tw_pkg::S_IDLE;
        end
      end

      tw_pkg::S_RM_RD: begin
        state_d = tw_pkg::S_RM_EV;
      end

      tw_pkg::S_RM_EV: begin
        if (valid_q[idx_q] && (rd_ent.tag == tag_q)) begin
          if (!rd_ent.lp && !fw_q) begin
            fw_d = 1'b1;
            wi_d = idx_q;
          end
          if (rd_ent.lp && !fl_q) begin
            fl_d = 1'b1;
            li_d = idx_q;
          end
        end
        if (idx_last) begin
          state_d = tw_pkg::S_RM_END;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = tw_pkg::S_RM_RD;
        end
      end

      tw_pkg::S_RM_END: begin
        // wheel match wins over a low precision match
        if (fw_q) begin
          valid_d[wi_q] = 1'b0;
        end else if (fl_q) begin
          valid_d[li_q] = 1'b0;
        end
        state_d = tw_pkg::S_IDLE;
      end

      tw_pkg::S_TW_RD: begin
        state_d = tw_pkg::S_TW_EV;
      end

      tw_pkg::S_TW_EV: begin
        if (valid_q[idx_q] && !rd_ent.lp && (rd_ent.slot == cur_q)) begin
          dly = now_q - rd_ent.last_fired;
          if (dly[tw_pkg::TimeW-1]) begin
            dly = '0;
          end
          lsum = tw_pkg::FracSumW'(rd_ent.lost) + tw_pkg::FracSumW'(rd_ent.frac);
          s9   = {1'b0, cur_q} + {1'b0, rd_ent.stride};
          if (s9 >= {1'b0, nsl_q}) begin
            s9 = s9 - {1'b0, nsl_q};
          end
          if (s9[tw_pkg::SlotW-1:0] == cur_q) begin
            s9 = {1'b0, cur_q} + 1'b1;
            if (s9 == {1'b0, nsl_q}) begin
              s9 = '0;
            end
          end
          e_w.last_fired = now_q;
          e_w.lost       = lsum[tw_pkg::LostW-1:0];
          e_w.slot       = s9[tw_pkg::SlotW-1:0];
          ram_we         = 1'b1;
          ram_wdata      = e_w;
          push           = 1'b1;
          push_tag       = rd_ent.tag;
          push_skip      = tw_pkg::TimeW'(lsum[tw_pkg::FracSumW-1:tw_pkg::LostW]);
          push_dly       = dly;
        end
        if (idx_last) begin
          idx_d   = '0;
          state_d = (qc_q == '0) ? tw_pkg::S_TL_RD : tw_pkg::S_TEND;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = tw_pkg::S_TW_RD;
        end
      end

      tw_pkg::S_TL_RD: begin
        state_d = tw_pkg::S_TL_EV;
      end

      tw_pkg::S_TL_EV: begin
        ent_d = rd_ent;
        diff  = now_q - rd_ent.next_due;
        if (valid_q[idx_q] && rd_ent.lp && (diff != '0) && !diff[tw_pkg::TimeW-1]) begin
          // whole periods missed
          div_start = 1'b1;
          div_num   = diff;
          div_den   = rd_ent.period;
          state_d   = tw_pkg::S_TL_DIV;
        end else if (idx_last) begin
          state_d = tw_pkg::S_TEND;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = tw_pkg::S_TL_RD;
        end
      end

      tw_pkg::S_TL_DIV: begin
        if (!div_busy_q) begin
          prod_d  = tw_pkg::TimeW'({16'd0, ent_q.period}) * (div_quo_q + 32'd1);
          state_d = tw_pkg::S_TL_WR;
        end
      end

      tw_pkg::S_TL_WR: begin
        e_w            = ent_q;
        e_w.next_due   = ent_q.next_due + prod_q;
        e_w.last_fired = now_q;
        ram_we         = 1'b1;
        ram_wdata      = e_w;
        push           = 1'b1;
        push_tag       = ent_q.tag;
        push_skip      = div_quo_q;
        push_dly       = now_q - ent_q.last_fired;
        if (idx_last) begin
          state_d = tw_pkg::S_TEND;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = tw_pkg::S_TL_RD;
        end
      end

      tw_pkg::S_TEND: begin
        flush = 1'b1;
        if ((cur_q + 1'b1) == nsl_q) begin
          cur_d = '0;
          qc_d  = '0;
        end else begin
          cur_d = cur_q + 1'b1;
          qc_d  = ((qc_q + 1'b1) == (nsl_q / tw_pkg::SlotW'(tw_pkg::LowPrecDiv))) ?
                  '0 : qc_q + 1'b1;
        end
        state_d = tw_pkg::S_IDLE;
      end

      default: begin
        state_d = tw_pkg::S_IDLE;
      end
    endcase
  end

  // result staging and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      olast_q  <= 1'b0;
      if (push) begin
        strobe_q <= pend_v_q;
        pend_v_q <= 1'b1;
      end else if (flush) begin
        strobe_q <= pend_v_q;
        olast_q  <= pend_v_q;
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push || flush) begin
      otag_q  <= pend_tag_q;
      oskip_q <= pend_skip_q;
      odly_q  <= pend_dly_q;
    end
    if (push) begin
      pend_tag_q  <= push_tag;
      pend_skip_q <= push_skip;
      pend_dly_q  <= push_dly;
    end
  end

  assign result_strobe_o = strobe_q;
  assign fired_tag_o     = otag_q;
  assign skipped_o       = oskip_q;
  assign last_delay_o    = odly_q;
  assign last_o          = olast_q;

  // checks
  a_last_strobe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_strobe_o)
    else $error("last without result strobe");

  a_strobe_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(state_q != tw_pkg::S_IDLE))
    else $error("result beat without a running item");

  a_tick_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !cfg_we_i && (mode_i == tw_pkg::MODE_TICK)) |=> busy)
    else $error("tick accepted but sequencer idle");

  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tw_pkg::S_IDLE) |-> !div_busy_q)
    else $error("divider running while idle");

endmodule

`default_nettype wire

// ===== dv/timer_wheel_multiplexer_test.sv =====
// ----------------------------------------------------------------------------
// timer_wheel_multiplexer_test
// self-checking bench: a stimulus table and random add/remove/tick beats
// under several tick resolutions, each firing checked against a predictor
// ----------------------------------------------------------------------------
`default_nettype none

module timer_wheel_multiplexer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int CycleLimit = 2_000_000;
  localparam int IdleWait   = 1300;   // rebuild sweep plus a slow add

  typedef struct {
    logic [tw_pkg::TagW-1:0]  tag;
    logic [tw_pkg::TimeW-1:0] skipped;
    logic [tw_pkg::TimeW-1:0] delay;
    logic                     last;
  } fire_t;

  typedef struct {
    logic [1:0]               mode;
    logic [tw_pkg::TagW-1:0]  tag;
    logic [tw_pkg::PerW-1:0]  period;
    logic [tw_pkg::TimeW-1:0] now;
    int                       exp_n;     // -1: predictor only
    logic [tw_pkg::TagW-1:0]  exp_tag;   // checked when exp_n is 1
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]               mode_i = '0;
  logic [tw_pkg::TagW-1:0]  timer_tag_i = '0;
  logic [tw_pkg::PerW-1:0]  period_ms_i = '0;
  logic [tw_pkg::TimeW-1:0] now_ms_i = '0;
  logic                     cfg_we_i = 1'b0;
  logic [tw_pkg::ResW-1:0]  cfg_wdata_i = '0;
  logic                     result_strobe_o;
  logic [tw_pkg::TagW-1:0]  fired_tag_o;
  logic [tw_pkg::TimeW-1:0] skipped_o;
  logic [tw_pkg::TimeW-1:0] last_delay_o;
  logic                     last_o;

  timer_wheel_multiplexer dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .timer_tag_i, .period_ms_i,
    .now_ms_i, .cfg_we_i, .cfg_wdata_i, .result_strobe_o, .fired_tag_o,
    .skipped_o, .last_delay_o, .last_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // predictor state
  bit                       t_valid [tw_pkg::MaxTimers];
  logic [tw_pkg::TagW-1:0]  t_tag   [tw_pkg::MaxTimers];
  int unsigned              t_per   [tw_pkg::MaxTimers];
  bit                       t_lp    [tw_pkg::MaxTimers];
  int unsigned              t_slot  [tw_pkg::MaxTimers];
  longint unsigned          t_lost  [tw_pkg::MaxTimers];
  int unsigned              t_fired [tw_pkg::MaxTimers];
  int unsigned              t_due   [tw_pkg::MaxTimers];
  int unsigned              cur_slot;
  int unsigned              res_ms;
  int unsigned              n_slots;

  fire_t fire_q[$];
  int    errors = 0;
  int    cycles = 0;
  int    acc_n = 0;
  row_t  rows[$];

  function automatic int unsigned clamp_res(int unsigned v);
    if (v < tw_pkg::ResMin) return tw_pkg::ResMin;
    if (v > tw_pkg::ResMax) return tw_pkg::ResMax;
    return v;
  endfunction

  function automatic void rebuild_wheel();
    n_slots = tw_pkg::WheelSpanMs / res_ms;
    cur_slot = 0;
    for (int i = 0; i < tw_pkg::MaxTimers; i++)
      if (t_valid[i] && !t_lp[i]) t_slot[i] = (t_per[i] / res_ms) % n_slots;
  endfunction

  // whole periods leave the 32.16 accumulator, fraction stays
  function automatic int unsigned take_skip(int i);
    longint unsigned l;
    l = t_lost[i] & 64'hFFFF_FFFF_FFFF;
    t_lost[i] = l & 64'hFFFF;
    return int'(l >> 16);
  endfunction

  function automatic void write_res(logic [tw_pkg::ResW-1:0] v);
    int unsigned r;
    r = clamp_res(v);
    if (r != res_ms) begin
      res_ms = r;
      rebuild_wheel();
    end
  endfunction

  function automatic int predict_item(logic [1:0] m, logic [tw_pkg::TagW-1:0] tag,
                                      logic [tw_pkg::PerW-1:0] per_in,
                                      logic [tw_pkg::TimeW-1:0] now);
    int unsigned per, cur, quarter, p, d, nxt, diff, skip;
    fire_t outs[$];
    fire_t f;
    per = (per_in == 0) ? 1 : per_in;
    if (m == tw_pkg::MODE_ADD) begin
      for (int i = 0; i < tw_pkg::MaxTimers; i++) begin
        if (t_valid[i]) continue;
        t_valid[i] = 1; t_tag[i] = tag; t_per[i] = per;
        t_lost[i] = 0; t_fired[i] = 0; t_slot[i] = 0; t_due[i] = 0;
        if (per >= tw_pkg::WheelSpanMs) begin
          t_lp[i] = 1;
          t_due[i] = now + per;
        end else begin
          t_lp[i] = 0;
          t_slot[i] = (per / res_ms + cur_slot) % n_slots;
        end
        break;
      end
      return 0;
    end
    if (m == tw_pkg::MODE_REMOVE) begin
      // wheel entries win over low precision ones
      for (int i = 0; i < tw_pkg::MaxTimers; i++)
        if (t_valid[i] && !t_lp[i] && t_tag[i] == tag) begin
          t_valid[i] = 0;
          return 0;
        end
      for (int i = 0; i < tw_pkg::MaxTimers; i++)
        if (t_valid[i] && t_lp[i] && t_tag[i] == tag) begin
          t_valid[i] = 0;
          return 0;
        end
      return 0;
    end
    if (m != tw_pkg::MODE_TICK) return 0;
    cur = cur_slot;
    quarter = n_slots / tw_pkg::LowPrecDiv;
    if (quarter == 0) quarter = 1;
    for (int i = 0; i < tw_pkg::MaxTimers; i++) begin
      if (!t_valid[i] || t_lp[i] || t_slot[i] != cur) continue;
      p = t_per[i];
      d = now - t_fired[i];
      if (d[31]) d = 0;
      t_fired[i] = now;
      if (p < res_ms) t_lost[i] += (longint'(res_ms - p) << 16) / p;
      nxt = (cur + p / res_ms) % n_slots;
      if (nxt == cur) nxt = (nxt + 1) % n_slots;
      t_slot[i] = nxt;
      f.tag = t_tag[i]; f.skipped = take_skip(i); f.delay = d; f.last = 0;
      outs.push_back(f);
    end
    // low precision pass once per quarter turn
    if (cur % quarter == 0) begin
      for (int i = 0; i < tw_pkg::MaxTimers; i++) begin
        if (!t_valid[i] || !t_lp[i]) continue;
        diff = now - t_due[i];
        if (diff == 0 || diff[31]) continue;
        p = t_per[i];
        t_lost[i] += longint'(diff / p) << 16;
        skip = take_skip(i);
        d = now - t_fired[i];
        t_fired[i] = now;
        t_due[i] += int'(longint'(p) * (longint'(skip) + 1));
        f.tag = t_tag[i]; f.skipped = skip; f.delay = d; f.last = 0;
        outs.push_back(f);
      end
    end
    cur_slot = (cur + 1) % n_slots;
    if (outs.size() > 0) outs[outs.size()-1].last = 1;
    foreach (outs[j]) fire_q.push_back(outs[j]);
    return outs.size();
  endfunction

  // compare pending firings first, then predict the beat taken at this edge
  always @(posedge clk_i) begin
    fire_t e;
    int n;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("FAILED: results differ");
      $finish;
    end
    if (rst_ni) begin
      if (result_strobe_o) begin
        if (fire_q.size() == 0) begin
          $display("%0t unexpected firing tag %h", $time, fired_tag_o);
          errors++;
        end else begin
          e = fire_q.pop_front();
          if (fired_tag_o !== e.tag || skipped_o !== e.skipped ||
              last_delay_o !== e.delay || last_o !== e.last) begin
            $display("%0t mismatch exp tag %h skip %0d delay %0d last %b",
                     $time, e.tag, e.skipped, e.delay, e.last);
            $display("%0t          got tag %h skip %0d delay %0d last %b",
                     $time, fired_tag_o, skipped_o, last_delay_o, last_o);
            errors++;
          end
        end
      end
      if (cfg_we_i) write_res(cfg_wdata_i);
      if (start && !busy) begin
        n = predict_item(mode_i, timer_tag_i, period_ms_i, now_ms_i);
        // the first beats are the table rows, in order
        if (acc_n < rows.size() && rows[acc_n].exp_n >= 0) begin
          if (n != rows[acc_n].exp_n ||
              (n == 1 && fire_q[fire_q.size()-1].tag !== rows[acc_n].exp_tag)) begin
            $display("%0t table row exp %0d firings tag %h, predictor %0d", $time,
                     rows[acc_n].exp_n, rows[acc_n].exp_tag, n);
            errors++;
          end
        end
        acc_n++;
      end
    end
  end

  logic [tw_pkg::TimeW-1:0] clock_ms;
  bit                       gaps_on;

  // holds start high until the beat is taken; the caller lowers it
  task automatic send_beat(logic [1:0] m, logic [tw_pkg::TagW-1:0] tag,
                           logic [tw_pkg::PerW-1:0] per,
                           logic [tw_pkg::TimeW-1:0] now);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= m; timer_tag_i <= tag; period_ms_i <= per; now_ms_i <= now;
    do @(posedge clk_i); while (!(start && !busy));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (busy || fire_q.size() != 0);
  endtask

  task automatic set_resolution(logic [tw_pkg::ResW-1:0] v);
    drain();
    repeat (IdleWait) @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_beat();
    int unsigned r, sel, idx;
    logic [tw_pkg::PerW-1:0] per;
    logic [tw_pkg::TagW-1:0] tag;
    r = $urandom_range(0, 99);
    if (r < 48) begin
      sel = $urandom_range(0, 19);
      if (sel == 0) clock_ms = $urandom();              // far jump, wraps too
      else if (sel == 1) clock_ms = clock_ms - $urandom_range(1, 3000);
      else if (sel == 2) clock_ms = clock_ms + $urandom_range(1000, 20000);
      else clock_ms = clock_ms + res_ms + $urandom_range(0, 3);
      send_beat(tw_pkg::MODE_TICK, tw_pkg::TagW'($urandom()),
                tw_pkg::PerW'($urandom()), clock_ms);
    end else if (r < 76) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2: per = tw_pkg::PerW'($urandom_range(1, res_ms));
        3, 4:    per = tw_pkg::PerW'($urandom_range(res_ms, 999));
        5:       per = tw_pkg::PerW'($urandom_range(1000, 4000));
        6:       per = tw_pkg::PerW'($urandom());
        7:       per = '0;
        8:       per = 16'hFFFF;
        default: per = tw_pkg::PerW'(res_ms * $urandom_range(1, 5));
      endcase
      send_beat(tw_pkg::MODE_ADD, tw_pkg::TagW'($urandom()), per, clock_ms);
    end else if (r < 94) begin
      tag = tw_pkg::TagW'($urandom());
      idx = $urandom_range(0, tw_pkg::MaxTimers-1);
      if ($urandom_range(0, 3) != 0 && t_valid[idx]) tag = t_tag[idx];
      send_beat(tw_pkg::MODE_REMOVE, tag, tw_pkg::PerW'($urandom()), $urandom());
    end else begin
      send_beat(ModeUnused, tw_pkg::TagW'($urandom()), tw_pkg::PerW'($urandom()),
                $urandom());
    end
  endtask

  logic [tw_pkg::ResW-1:0] res_list[$];

  initial begin
    rows = '{
      '{tw_pkg::MODE_TICK,   16'h0000, 16'd0,     32'd0,          0,  16'h0000},  // empty table
      '{tw_pkg::MODE_ADD,    16'hFFFF, 16'd0,     32'd0,          0,  16'h0000},  // zero period
      '{tw_pkg::MODE_ADD,    16'h0000, 16'hFFFF,  32'd0,          0,  16'h0000},  // low precision
      '{tw_pkg::MODE_ADD,    16'h1234, 16'd999,   32'd100,        0,  16'h0000},  // longest wheel
      '{tw_pkg::MODE_TICK,   16'h0000, 16'd0,     32'd20,         1,  16'hFFFF},
      '{tw_pkg::MODE_TICK,   16'hAAAA, 16'h5555,  32'hFFFF_FFFF, -1,  16'h0000},  // negative delay
      '{tw_pkg::MODE_ADD,    16'h0001, 16'd1000,  32'h7FFF_FFFF,  0,  16'h0000},
      '{tw_pkg::MODE_REMOVE, 16'h5555, 16'd0,     32'd0,          0,  16'h0000},  // no match
      '{tw_pkg::MODE_REMOVE, 16'h1234, 16'd0,     32'd0,          0,  16'h0000},
      '{ModeUnused,          16'hFFFF, 16'hFFFF,  32'hFFFF_FFFF,  0,  16'h0000},  // ignored mode
      '{tw_pkg::MODE_ADD,    16'h0002, 16'd20,    32'd40,        -1,  16'h0000},
      '{tw_pkg::MODE_ADD,    16'h0002, 16'd7,     32'd40,        -1,  16'h0000}   // equal tags
    };
    res_list = '{8'd5, 8'd250, 8'd0, 8'd255, 8'd20, 8'd20, 8'd7, 8'd100,
                 8'd33, 8'd5};
    res_ms = tw_pkg::ResReset;
    rebuild_wheel();
    for (int i = 0; i < tw_pkg::MaxTimers; i++) t_valid[i] = 0;
    gaps_on = 1;
    clock_ms = 32'd60;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) begin
      send_beat(rows[i].mode, rows[i].tag, rows[i].period, rows[i].now);
    end
    // fill past capacity so the extra adds are dropped
    for (int i = 0; i < tw_pkg::MaxTimers + 2; i++)
      send_beat(tw_pkg::MODE_ADD, tw_pkg::TagW'(16'h0100 + i),
                tw_pkg::PerW'($urandom_range(1, 60)), clock_ms);
    for (int i = 0; i < 12; i++) begin
      clock_ms = clock_ms + res_ms;
      send_beat(tw_pkg::MODE_TICK, tw_pkg::TagW'($urandom()),
                tw_pkg::PerW'($urandom()), clock_ms);
    end

    foreach (res_list[p]) begin
      set_resolution(res_list[p]);
      if (p == res_list.size() - 2) gaps_on = 0;   // last two parts run without gaps
      for (int j = 0; j < 40; j++) begin
        random_beat();
        if (p == 3 && j == 20) drain();           // sender waits for all firings
      end
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (fire_q.size() != 0) begin
      $display("%0t %0d firings never came, next tag %h", $time, fire_q.size(),
               fire_q[0].tag);
      errors++;
    end
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== timer_wheel_multiplexer.f =====
hdl/tw_pkg.sv
hdl/tw_ram.sv
hdl/timer_wheel_multiplexer.sv
dv/timer_wheel_multiplexer_test.sv
